/* sv/tqec_pkg.sv */
// ----------------------------------------------------------------------------
// Thrust to ESC command package
// Widths, register indexes, reset values and the per-stage item types shared
// by the front end, the square-root cells, the divider cells and the top level.
// ----------------------------------------------------------------------------
package tqec_pkg;

   // Port widths.
   localparam int FORCE_W = 24;
   localparam int VOLT_W  = 16;
   localparam int COEF_W  = 32;
   localparam int CMD_W   = 16;
   localparam int IDX_W   = 3;

   // Register indexes on the configuration port.
   localparam logic [IDX_W-1:0] REG_COEF_QUAD        = 3'd0;
   localparam logic [IDX_W-1:0] REG_COEF_LIN         = 3'd1;
   localparam logic [IDX_W-1:0] REG_COEF_VOLT_OFFSET = 3'd2;
   localparam logic [IDX_W-1:0] REG_COEF_VOLT_LIN    = 3'd3;
   localparam logic [IDX_W-1:0] REG_COEF_CONST       = 3'd4;

   // Register reset values.
   localparam logic [COEF_W-1:0] RST_COEF_QUAD        = 32'd23329500;
   localparam logic [COEF_W-1:0] RST_COEF_LIN         = 32'hFF3CAEEC;
   localparam logic [COEF_W-1:0] RST_COEF_VOLT_OFFSET = 32'hFFFE42EB;
   localparam logic [COEF_W-1:0] RST_COEF_VOLT_LIN    = 32'd623586;
   localparam logic [COEF_W-1:0] RST_COEF_CONST       = 32'd1554252;

   // Internal datapath widths.
   localparam int BN_W    = 49;   // linear term B and constant term K
   localparam int WIDE_W  = 100;  // discriminant before the sign check
   localparam int DISC_W  = 98;   // non-negative discriminant
   localparam int ROOT_W  = 49;   // square root, one cell per bit
   localparam int NUM_W   = 72;   // offset numerator of the final division
   localparam int DEN_W   = 46;   // 10000 times the magnitude of a
   localparam int OFF_W   = 61;   // a times 10000 times 2^14
   localparam int REM_W   = 62;   // divider partial remainder
   localparam int Q_W     = 16;   // divider quotient, one cell per bit

   // Scale constants.
   localparam logic [13:0] PWM_UNIT  = 14'd10000;
   localparam logic [27:0] PWM_OFFSET = 28'd163840000;

   localparam logic signed [CMD_W-1:0] CMD_MAX = 16'sh7FFF;
   localparam logic signed [CMD_W-1:0] CMD_MIN = 16'sh8000;

   // Item travelling along the square-root cells.
   typedef struct packed {
      logic                     valid;
      logic                     zero;   // result forced to zero
      logic                     inval;  // no real root, or a is zero
      logic [DISC_W-1:0]        rem;
      logic [ROOT_W-1:0]        root;
      logic signed [BN_W-1:0]   bn;
   } sq_type;

   // Item travelling along the divider cells.
   typedef struct packed {
      logic              valid;
      logic              zero;
      logic              inval;
      logic              sat_hi;
      logic              sat_lo;
      logic [REM_W-1:0]  rem;
      logic [Q_W-1:0]    quo;
   } dv_type;

endpackage

/* sv/tqec_front.sv */
// ----------------------------------------------------------------------------
// Thrust to ESC command front end
// Forms B and K from the item and the coefficients, squares B and multiplies
// a by K in split partial products, and assembles the discriminant.
// ----------------------------------------------------------------------------
module tqec_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  enable,
   input  logic                                  in_valid,
   input  logic signed [tqec_pkg::FORCE_W-1:0]   force_req,
   input  logic [tqec_pkg::VOLT_W-1:0]           voltage,
   input  logic signed [tqec_pkg::COEF_W-1:0]    coef_quad,
   input  logic signed [tqec_pkg::COEF_W-1:0]    coef_lin,
   input  logic signed [tqec_pkg::COEF_W-1:0]    coef_volt_offset,
   input  logic signed [tqec_pkg::COEF_W-1:0]    coef_volt_lin,
   input  logic signed [tqec_pkg::COEF_W-1:0]    coef_const,
   output tqec_pkg::sq_type                      sq_out
);
   import tqec_pkg::*;

   logic signed [VOLT_W:0]  volt_s;
   logic signed [BN_W-1:0]  prod_b, prod_k, bn_in, kn_in;

   logic                    valid_a_ff, zero_a_ff, inval_a_ff;
   logic signed [BN_W-1:0]  bn_a_ff, kn_a_ff;

   logic [BN_W-1:0]         bn_mag, kn_mag;
   logic [COEF_W-1:0]       ca_mag;
   logic [49:0]             p_hh_in, p_hh_ff;
   logic [48:0]             p_hl_in, p_hl_ff;
   logic [47:0]             p_ll_in, p_ll_ff;
   logic [56:0]             p_kh_in, p_kh_ff;
   logic [55:0]             p_kl_in, p_kl_ff;
   logic                    valid_b_ff, zero_b_ff, inval_b_ff, tneg_b_ff;
   logic signed [BN_W-1:0]  bn_b_ff;

   logic [WIDE_W-1:0]       bsq, tmag, disc;

   // Stage A: linear and constant terms.
   assign volt_s = $signed({1'b0, voltage});

   always_comb begin
      prod_b = coef_volt_lin * volt_s;
      prod_k = coef_volt_offset * volt_s;
      bn_in  = prod_b + (BN_W'(coef_lin) <<< 10);
      kn_in  = prod_k + ((BN_W'(coef_const) - BN_W'(force_req)) <<< 10);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (enable) begin
         valid_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         bn_a_ff    <= bn_in;
         kn_a_ff    <= kn_in;
         zero_a_ff  <= force_req[FORCE_W-1] || (coef_quad == '0);
         inval_a_ff <= !force_req[FORCE_W-1] && (coef_quad == '0);
      end
   end

   // Stage B: partial products of B squared and a times K.
   always_comb begin
      bn_mag  = bn_a_ff[BN_W-1] ? BN_W'(-bn_a_ff) : BN_W'(bn_a_ff);
      kn_mag  = kn_a_ff[BN_W-1] ? BN_W'(-kn_a_ff) : BN_W'(kn_a_ff);
      ca_mag  = coef_quad[COEF_W-1] ? COEF_W'(-coef_quad) : COEF_W'(coef_quad);
      p_hh_in = bn_mag[48:24] * bn_mag[48:24];
      p_hl_in = bn_mag[48:24] * bn_mag[23:0];
      p_ll_in = bn_mag[23:0] * bn_mag[23:0];
      p_kh_in = ca_mag * kn_mag[48:24];
      p_kl_in = ca_mag * kn_mag[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (enable) begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p_hh_ff    <= p_hh_in;
         p_hl_ff    <= p_hl_in;
         p_ll_ff    <= p_ll_in;
         p_kh_ff    <= p_kh_in;
         p_kl_ff    <= p_kl_in;
         tneg_b_ff  <= coef_quad[COEF_W-1] ^ kn_a_ff[BN_W-1];
         bn_b_ff    <= bn_a_ff;
         zero_b_ff  <= zero_a_ff;
         inval_b_ff <= inval_a_ff;
      end
   end

   // Stage C: discriminant B*B - 4096*a*K and its sign check.
   always_comb begin
      bsq  = (WIDE_W'(p_hh_ff) << 48) + (WIDE_W'(p_hl_ff) << 25) + WIDE_W'(p_ll_ff);
      tmag = ((WIDE_W'(p_kh_ff) << 24) + WIDE_W'(p_kl_ff)) << 12;
      disc = tneg_b_ff ? (bsq + tmag) : (bsq - tmag);

      sq_out.valid = valid_b_ff;
      sq_out.zero  = zero_b_ff || disc[WIDE_W-1];
      sq_out.inval = inval_b_ff || (!zero_b_ff && disc[WIDE_W-1]);
      sq_out.rem   = disc[DISC_W-1:0];
      sq_out.root  = '0;
      sq_out.bn    = bn_b_ff;
   end

endmodule

/* sv/tqec_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// Thrust to ESC command square-root cell
// Decides one bit of the integer square root by trial subtraction and hands
// the item on to the next cell.
// ----------------------------------------------------------------------------
module tqec_sqrt_cell #(
   parameter int CELL_BIT = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  tqec_pkg::sq_type  cell_in,
   output tqec_pkg::sq_type  cell_out
);
   import tqec_pkg::*;

   logic [DISC_W-1:0] trial;
   sq_type            cell_in_next;
   sq_type            cell_ff;

   // Growing the root by this bit costs 2^(b+1)*root + 2^(2b).
   always_comb begin
      trial = (DISC_W'(cell_in.root) << (CELL_BIT + 1)) | (DISC_W'(1) << (2 * CELL_BIT));
      cell_in_next = cell_in;
      if (cell_in.rem >= trial) begin
         cell_in_next.rem            = cell_in.rem - trial;
         cell_in_next.root[CELL_BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (enable) begin
         cell_ff <= cell_in_next;
      end
   end

   assign cell_out = cell_ff;

endmodule

/* sv/tqec_div_cell.sv */
// ----------------------------------------------------------------------------
// Thrust to ESC command divider cell
// Decides one quotient bit of the restoring division by the scaled quadratic
// coefficient and hands the item on to the next cell.
// ----------------------------------------------------------------------------
module tqec_div_cell #(
   parameter int CELL_BIT = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic [tqec_pkg::DEN_W-1:0]    den,
   input  tqec_pkg::dv_type              cell_in,
   output tqec_pkg::dv_type              cell_out
);
   import tqec_pkg::*;

   logic [REM_W-1:0] den_sh;
   dv_type           cell_in_next;
   dv_type           cell_ff;

   // Subtract the shifted divisor when it fits.
   always_comb begin
      den_sh = REM_W'(den) << CELL_BIT;
      cell_in_next = cell_in;
      if (cell_in.rem >= den_sh) begin
         cell_in_next.rem           = cell_in.rem - den_sh;
         cell_in_next.quo[CELL_BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (enable) begin
         cell_ff <= cell_in_next;
      end
   end

   assign cell_out = cell_ff;

endmodule

/* sv/thrust_quadratic_to_esc_command.sv */
// ----------------------------------------------------------------------------
// Thrust to ESC command, quadratic thrust model
// Solves a*p*p + (b + d*V)*p + c*V + e = F for the positive root p and
// returns (p - 10000)/10000 as a saturated Q2.14 command.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the req_ channel (force_req, voltage) with valid/ready and
// leave on the rsp_ channel (command, invalid), one result per item, in order.
// The coefficients a..e are written on the csr_ port, index 0 to 4, while no
// item is in flight; writes to other indexes are dropped.
// From acceptance to rsp_valid an item passes two front-end stages,
// 49 square-root cells (one root bit each), two stages that form and range
// check the numerator, 16 divider cells (one quotient bit each) and the
// output register.
// Throughput is one item per cycle; the chain of cells holds up to 70 items.
// When the receiver holds rsp_ready low with a result waiting, the whole
// chain stalls and req_ready drops in the same cycle; bubbles in the chain
// are not squeezed out.
// Reset clears all valid bits and loads the coefficient registers with their
// default model values; the block takes items in the first cycle after reset.
// Negative force gives command 0 with invalid clear; otherwise a zero a or a
// negative discriminant gives command 0 with invalid set.
// ----------------------------------------------------------------------------
module thrust_quadratic_to_esc_command (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [tqec_pkg::FORCE_W-1:0]   req_force_req,
   input  logic [tqec_pkg::VOLT_W-1:0]           req_voltage,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [tqec_pkg::CMD_W-1:0]     rsp_command,
   output logic                                  rsp_invalid,
   input  logic                                  csr_write_enable,
   input  logic [tqec_pkg::IDX_W-1:0]            csr_index,
   input  logic [tqec_pkg::COEF_W-1:0]           csr_write_data
);
   import tqec_pkg::*;

   logic signed [COEF_W-1:0] coef_quad_ff, coef_lin_ff, coef_volt_offset_ff;
   logic signed [COEF_W-1:0] coef_volt_lin_ff, coef_const_ff;

   logic [DEN_W-1:0]         den_in, den_ff;
   logic signed [OFF_W-1:0]  off_in, off_ff;

   logic                     enable;

   sq_type                   sq_chain [ROOT_W:0];
   dv_type                   dv_chain [Q_W:0];

   logic signed [ROOT_W:0]   diff;
   logic signed [NUM_W-1:0]  num_raw, num_in, num_ff;
   logic                     valid_d_ff, zero_d_ff, inval_d_ff;
   dv_type                   dv_in, dv_ff;

   logic signed [CMD_W-1:0]  cmd_in, rsp_command_ff;
   logic                     rsp_valid_ff, rsp_invalid_ff;

   // Coefficient registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_quad_ff        <= RST_COEF_QUAD;
         coef_lin_ff         <= RST_COEF_LIN;
         coef_volt_offset_ff <= RST_COEF_VOLT_OFFSET;
         coef_volt_lin_ff    <= RST_COEF_VOLT_LIN;
         coef_const_ff       <= RST_COEF_CONST;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_COEF_QUAD:        coef_quad_ff        <= csr_write_data;
            REG_COEF_LIN:         coef_lin_ff         <= csr_write_data;
            REG_COEF_VOLT_OFFSET: coef_volt_offset_ff <= csr_write_data;
            REG_COEF_VOLT_LIN:    coef_volt_lin_ff    <= csr_write_data;
            REG_COEF_CONST:       coef_const_ff       <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Divisor and offset derived from a, refreshed every cycle.
   always_comb begin
      den_in = (coef_quad_ff[COEF_W-1] ? COEF_W'(-coef_quad_ff) : COEF_W'(coef_quad_ff))
               * PWM_UNIT;
      off_in = coef_quad_ff * $signed({1'b0, PWM_OFFSET});
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      off_ff <= off_in;
   end

   // The whole chain moves unless a result waits at the output; no item is
   // taken while reset is held.
   assign enable    = !rsp_valid_ff || rsp_ready;
   assign req_ready = enable && !reset;

   tqec_front u_front (
      .clock            (clock),
      .reset            (reset),
      .enable           (enable),
      .in_valid         (req_valid),
      .force_req        (req_force_req),
      .voltage          (req_voltage),
      .coef_quad        (coef_quad_ff),
      .coef_lin         (coef_lin_ff),
      .coef_volt_offset (coef_volt_offset_ff),
      .coef_volt_lin    (coef_volt_lin_ff),
      .coef_const       (coef_const_ff),
      .sq_out           (sq_chain[ROOT_W])
   );

   // Square-root cells, most significant bit first.
   for (genvar g = ROOT_W - 1; g >= 0; g--) begin : g_sqrt
      tqec_sqrt_cell #(.CELL_BIT(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .cell_in  (sq_chain[g+1]),
         .cell_out (sq_chain[g])
      );
   end

   // Numerator (S - B)*2^19 - a*163840000, sign-corrected and offset by
   // 2^15 divisors so that an in-range floor quotient lands in 0..65535.
   always_comb begin
      diff    = $signed({1'b0, sq_chain[0].root}) - (ROOT_W+1)'(sq_chain[0].bn);
      num_raw = (NUM_W'(diff) <<< 19) - NUM_W'(off_ff);
      if (coef_quad_ff[COEF_W-1]) begin
         num_in = -num_raw + $signed(NUM_W'(den_ff) << 15);
      end else begin
         num_in = num_raw + $signed(NUM_W'(den_ff) << 15);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d_ff <= 1'b0;
      end else if (enable) begin
         valid_d_ff <= sq_chain[0].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         num_ff     <= num_in;
         zero_d_ff  <= sq_chain[0].zero;
         inval_d_ff <= sq_chain[0].inval;
      end
   end

   // Range check ahead of the divider.
   always_comb begin
      dv_in.valid  = valid_d_ff;
      dv_in.zero   = zero_d_ff;
      dv_in.inval  = inval_d_ff;
      dv_in.sat_lo = num_ff[NUM_W-1];
      dv_in.sat_hi = !num_ff[NUM_W-1] && (num_ff >= $signed(NUM_W'(den_ff) << Q_W));
      dv_in.rem    = num_ff[REM_W-1:0];
      dv_in.quo    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff.valid <= 1'b0;
      end else if (enable) begin
         dv_ff <= dv_in;
      end
   end

   assign dv_chain[Q_W] = dv_ff;

   // Divider cells, most significant quotient bit first.
   for (genvar g = Q_W - 1; g >= 0; g--) begin : g_div
      tqec_div_cell #(.CELL_BIT(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .den      (den_ff),
         .cell_in  (dv_chain[g+1]),
         .cell_out (dv_chain[g])
      );
   end

   // Remove the quotient offset and apply the special cases.
   always_comb begin
      if (dv_chain[0].zero) begin
         cmd_in = '0;
      end else if (dv_chain[0].sat_lo) begin
         cmd_in = CMD_MIN;
      end else if (dv_chain[0].sat_hi) begin
         cmd_in = CMD_MAX;
      end else begin
         cmd_in = $signed({~dv_chain[0].quo[Q_W-1], dv_chain[0].quo[Q_W-2:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= dv_chain[0].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_command_ff <= cmd_in;
         rsp_invalid_ff <= dv_chain[0].inval;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_command = rsp_command_ff;
   assign rsp_invalid = rsp_invalid_ff;

endmodule
